>>> hw/rtl/api_frame_receiver_with_reply_macros.svh
// ---------------------------------------------------------------------------
// api_frame_receiver_with_reply_macros.svh
// Assertion macros shared by the frame receiver RTL.
// ---------------------------------------------------------------------------
`ifndef API_FRAME_RECEIVER_WITH_REPLY_MACROS_SVH
`define API_FRAME_RECEIVER_WITH_REPLY_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AFR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/afr_pkg.sv
// ---------------------------------------------------------------------------
// afr_pkg
// Types and constants of the API frame receiver with reply.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package afr_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_UNPAIR_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFILL_CHARGE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_STEP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JOY_NEUTRAL    = 2'd3;

  localparam logic [15:0] RST_UNPAIR_TIMEOUT = 16'd4000;
  localparam logic [7:0]  RST_REFILL_CHARGE  = 8'd200;
  localparam logic [7:0]  RST_CHARGE_STEP    = 8'd8;
  localparam logic [7:0]  RST_JOY_NEUTRAL    = 8'd127;
  localparam logic [7:0]  RST_CHARGE         = 8'hFF;

  // Frame layout
  localparam int unsigned WIN_LEN = 13;
  localparam logic [7:0] SOF        = 8'h7E;
  localparam logic [7:0] LEN_HI     = 8'h00;
  localparam logic [7:0] RX_LEN_LO  = 8'h09;
  localparam logic [7:0] RX_API_ID  = 8'h81;
  localparam logic [7:0] FRAME_TAG  = 8'h21;
  localparam logic [7:0] CKS_BASE   = 8'hFF;

  // Command codes in slot 8, fire codes in slot 11
  localparam logic [7:0] CMD_DRIVE  = 8'h00;
  localparam logic [7:0] CMD_CHARGE = 8'h01;
  localparam logic [7:0] CMD_PAIR   = 8'h02;
  localparam logic [7:0] DIGI_HOLD  = 8'h00;
  localparam logic [7:0] DIGI_FIRE  = 8'h01;

  localparam logic [1:0] CANNON_NONE  = 2'd0;
  localparam logic [1:0] CANNON_START = 2'd1;
  localparam logic [1:0] CANNON_STOP  = 2'd2;

  // Reply frame: 7E 00 06 01 00 21 peer 01 charge chk
  localparam logic [7:0] TX_LEN_LO = 8'h06;
  localparam logic [7:0] TX_API_ID = 8'h01;
  localparam logic [7:0] TX_OPT    = 8'h00;
  localparam logic [7:0] TX_STATUS = 8'h01;
  localparam int unsigned TX_BEATS = 10;
  localparam int unsigned BEAT_W   = 4;
  localparam logic [BEAT_W-1:0] BEAT_LAST = BEAT_W'(TX_BEATS - 1);

  typedef enum logic {
    JOB_REPLY,
    JOB_UNPAIR
  } afr_job_kind_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } afr_in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       frame_last;
    logic       paired_event;
    logic       unpaired_event;
    logic       charging_event;
    logic       drive_event;
    logic [7:0] throttle;
    logic [7:0] direction;
    logic [1:0] cannon_cmd;
    logic [7:0] charge_level;
  } afr_out_t;

  // Work handed from the front to the back
  typedef struct packed {
    afr_job_kind_t kind;
    logic          ev_pair;
    logic          ev_chg;
    logic          ev_drive;
    logic [7:0]    throttle;
    logic [7:0]    direction;
    logic [1:0]    cannon;
    logic [7:0]    peer;
    logic [7:0]    charge;
  } afr_job_t;

endpackage

>>> hw/rtl/afr_front.sv
// ---------------------------------------------------------------------------
// afr_front
// Frame window, checksum check, pairing/charge/drive rules and unpair timer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module afr_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  afr_pkg::afr_in_t                 in_item,
  input  logic                             cfg_we,
  input  logic [afr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [afr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                             push,
  output afr_pkg::afr_job_t                job
);

  logic [15:0] timeout_r;
  logic [7:0]  refill_r;
  logic [7:0]  step_r;
  logic [7:0]  neutral_r;

  logic [7:0]  win_r [afr_pkg::WIN_LEN];
  logic [7:0]  win_nxt [afr_pkg::WIN_LEN];
  logic [7:0]  nw [afr_pkg::WIN_LEN];
  logic        frame_open_r, frame_open_nxt;
  logic        paired_r, paired_nxt;
  logic [7:0]  peer_r, peer_nxt;
  logic        refill_pending_r, refill_pending_nxt;
  logic [7:0]  charge_r, charge_nxt;
  logic        timer_running_r, timer_running_nxt;
  logic [15:0] timer_count_r, timer_count_nxt;

  logic [7:0]  sum_a, sum_b, sum_c, sum_d, sum_all;
  logic        frame_ok;
  logic        is_pair, is_peer;
  logic [7:0]  c_base, c_mv, c_fire;
  logic        moved, fire;
  logic [15:0] cnt_dec;

  // Window after shifting in the current byte
  always_comb begin
    for (int i = 0; i < afr_pkg::WIN_LEN - 1; i++) begin
      nw[i] = win_r[i+1];
    end
    nw[afr_pkg::WIN_LEN-1] = in_item.rx_byte;
  end

  // Slots 3..11 summed as a shallow tree
  assign sum_a   = (nw[3] + nw[4]) + (nw[5] + nw[6]);
  assign sum_b   = (nw[7] + nw[8]) + (nw[9] + nw[10]);
  assign sum_c   = sum_a + sum_b;
  assign sum_d   = nw[11];
  assign sum_all = sum_c + sum_d;

  assign frame_ok = (nw[12] == (afr_pkg::CKS_BASE - sum_all)) &&
                    (nw[0] == afr_pkg::SOF) && (nw[1] == afr_pkg::LEN_HI) &&
                    (nw[2] == afr_pkg::RX_LEN_LO) && (nw[3] == afr_pkg::RX_API_ID) &&
                    (nw[4] == afr_pkg::FRAME_TAG);

  assign is_pair = !paired_r && (nw[8] == afr_pkg::CMD_PAIR) &&
                   (nw[9] == afr_pkg::FRAME_TAG);
  assign is_peer = paired_r && (nw[4] == afr_pkg::FRAME_TAG) && (nw[5] == peer_r);

  // Charge path for a frame from the peer
  assign c_base = refill_pending_r ? refill_r : charge_r;
  assign moved  = (nw[9] != neutral_r) || (nw[10] != neutral_r);
  assign c_mv   = moved ? (c_base - 8'd1) : c_base;
  assign fire   = (nw[11] == afr_pkg::DIGI_FIRE) && (c_mv != 8'd0);
  assign c_fire = fire ? (c_mv - 8'd1) : c_mv;

  assign cnt_dec = (timer_count_r != 16'd0) ? (timer_count_r - 16'd1) : 16'd0;

  always_comb begin
    win_nxt            = win_r;
    frame_open_nxt     = frame_open_r;
    paired_nxt         = paired_r;
    peer_nxt           = peer_r;
    refill_pending_nxt = refill_pending_r;
    charge_nxt         = charge_r;
    timer_running_nxt  = timer_running_r;
    timer_count_nxt    = timer_count_r;
    push               = 1'b0;
    job                = '0;
    job.kind           = afr_pkg::JOB_REPLY;

    if (accept) begin
      if (in_item.mode) begin
        // Millisecond tick: run the unpair timer
        if (timer_running_r) begin
          timer_count_nxt = cnt_dec;
          if (cnt_dec == 16'd0) begin
            timer_running_nxt = 1'b0;
            paired_nxt        = 1'b0;
            push              = 1'b1;
            job.kind          = afr_pkg::JOB_UNPAIR;
            job.charge        = charge_r;
          end
        end
      end else if (in_item.rx_byte == afr_pkg::SOF) begin
        for (int i = 0; i < afr_pkg::WIN_LEN; i++) begin
          win_nxt[i] = 8'h00;
        end
        win_nxt[afr_pkg::WIN_LEN-1] = afr_pkg::SOF;
        frame_open_nxt = 1'b1;
      end else if (frame_open_r) begin
        win_nxt = nw;
        if (frame_ok) begin
          if (is_pair) begin
            peer_nxt           = nw[10];
            paired_nxt         = 1'b1;
            refill_pending_nxt = 1'b1;
            job.ev_pair        = 1'b1;
          end else if (is_peer) begin
            timer_running_nxt  = 1'b1;
            timer_count_nxt    = timeout_r;
            refill_pending_nxt = 1'b0;
            charge_nxt         = c_base;
            if (nw[8] == afr_pkg::CMD_CHARGE) begin
              charge_nxt = c_base + step_r;
              job.ev_chg = 1'b1;
            end else if (nw[8] == afr_pkg::CMD_DRIVE) begin
              job.ev_drive = 1'b1;
              if (c_base == 8'd0) begin
                job.throttle  = neutral_r;
                job.direction = neutral_r;
              end else begin
                job.throttle  = nw[9];
                job.direction = nw[10];
                charge_nxt    = c_fire;
                if (fire) begin
                  job.cannon = afr_pkg::CANNON_START;
                end else if (nw[11] == afr_pkg::DIGI_HOLD) begin
                  job.cannon = afr_pkg::CANNON_STOP;
                end
              end
            end
          end
          frame_open_nxt = 1'b0;
          push           = 1'b1;
          job.peer       = peer_nxt;
          job.charge     = charge_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r        <= afr_pkg::RST_UNPAIR_TIMEOUT;
      refill_r         <= afr_pkg::RST_REFILL_CHARGE;
      step_r           <= afr_pkg::RST_CHARGE_STEP;
      neutral_r        <= afr_pkg::RST_JOY_NEUTRAL;
      for (int i = 0; i < afr_pkg::WIN_LEN; i++) begin
        win_r[i] <= 8'h00;
      end
      frame_open_r     <= 1'b0;
      paired_r         <= 1'b0;
      peer_r           <= 8'h00;
      refill_pending_r <= 1'b0;
      charge_r         <= afr_pkg::RST_CHARGE;
      timer_running_r  <= 1'b0;
      timer_count_r    <= 16'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          afr_pkg::CFG_UNPAIR_TIMEOUT: timeout_r <= cfg_wdata;
          afr_pkg::CFG_REFILL_CHARGE:  refill_r  <= cfg_wdata[7:0];
          afr_pkg::CFG_CHARGE_STEP:    step_r    <= cfg_wdata[7:0];
          afr_pkg::CFG_JOY_NEUTRAL:    neutral_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      win_r            <= win_nxt;
      frame_open_r     <= frame_open_nxt;
      paired_r         <= paired_nxt;
      peer_r           <= peer_nxt;
      refill_pending_r <= refill_pending_nxt;
      charge_r         <= charge_nxt;
      timer_running_r  <= timer_running_nxt;
      timer_count_r    <= timer_count_nxt;
    end
  end

endmodule

>>> hw/rtl/afr_queue.sv
// ---------------------------------------------------------------------------
// afr_queue
// Short job queue between the front and the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module afr_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  afr_pkg::afr_job_t push_job,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output afr_pkg::afr_job_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  afr_pkg::afr_job_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : (wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : (rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hw/rtl/afr_back.sv
// ---------------------------------------------------------------------------
// afr_back
// Serializes queued jobs into reply bytes or unpair results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module afr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  afr_pkg::afr_job_t job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output afr_pkg::afr_out_t out_data
);

  logic [afr_pkg::BEAT_W-1:0] beat_r, beat_nxt;
  logic                       out_valid_r, out_valid_nxt;
  afr_pkg::afr_out_t          out_r, res;
  logic                       load, last;
  logic [7:0]                 tx_chk, tx_b;

  assign load   = job_valid && (!out_valid_r || !out_stall);
  assign last   = (job.kind == afr_pkg::JOB_UNPAIR) || (beat_r == afr_pkg::BEAT_LAST);
  assign pop    = load && last;
  assign tx_chk = afr_pkg::CKS_BASE - (afr_pkg::TX_API_ID + afr_pkg::TX_OPT +
                  afr_pkg::FRAME_TAG + job.peer + afr_pkg::TX_STATUS + job.charge);

  always_comb begin
    case (beat_r)
      4'd0:    tx_b = afr_pkg::SOF;
      4'd1:    tx_b = afr_pkg::LEN_HI;
      4'd2:    tx_b = afr_pkg::TX_LEN_LO;
      4'd3:    tx_b = afr_pkg::TX_API_ID;
      4'd4:    tx_b = afr_pkg::TX_OPT;
      4'd5:    tx_b = afr_pkg::FRAME_TAG;
      4'd6:    tx_b = job.peer;
      4'd7:    tx_b = afr_pkg::TX_STATUS;
      4'd8:    tx_b = job.charge;
      4'd9:    tx_b = tx_chk;
      default: tx_b = 8'h00;
    endcase
  end

  always_comb begin
    res              = '0;
    res.charge_level = job.charge;
    res.frame_last   = last;
    if (job.kind == afr_pkg::JOB_UNPAIR) begin
      res.unpaired_event = 1'b1;
    end else begin
      res.tx_valid = 1'b1;
      res.tx_byte  = tx_b;
      if (beat_r == '0) begin
        res.paired_event   = job.ev_pair;
        res.charging_event = job.ev_chg;
        res.drive_event    = job.ev_drive;
        res.throttle       = job.throttle;
        res.direction      = job.direction;
        res.cannon_cmd     = job.cannon;
      end
    end
  end

  always_comb begin
    beat_nxt      = beat_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
      beat_nxt      = last ? '0 : (beat_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      beat_r      <= beat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hw/rtl/api_frame_receiver_with_reply.sv
// ---------------------------------------------------------------------------
// api_frame_receiver_with_reply
// Receives fixed-size API frames and ticks, runs the pairing/charge/drive
// rules and sends a 10-byte reply per valid frame.
// ---------------------------------------------------------------------------
//  channel | ports                        | item
//  --------+------------------------------+-------------------------------
//  in      | in_valid, in_stall, in_data  | received byte or 1 ms tick
//  out     | out_valid, out_stall, out_data | reply byte or unpair result
//  cfg     | cfg_we, cfg_index, cfg_wdata | register write, no read-back
//
//  The front takes one item per cycle while in_stall is low; its rules
//  settle in that cycle. The back sends one result per cycle while out_stall
//  is low: 10 for a valid frame, 1 for timer expiry.
//  in_stall rises only when all QUEUE_DEPTH job slots are taken.
//  Reset is synchronous and active low; no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "api_frame_receiver_with_reply_macros.svh"

module api_frame_receiver_with_reply #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  afr_pkg::afr_in_t               in_data,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output afr_pkg::afr_out_t              out_data,
  // Configuration writes
  input  logic                           cfg_we,
  input  logic [afr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic              in_accept;
  logic              job_push;
  afr_pkg::afr_job_t job_in;
  logic              q_full;
  logic              q_valid;
  afr_pkg::afr_job_t q_head;
  logic              q_pop;

  // Hold input while the queue has no free slot
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  // Front: window, frame check, rules, timer
  afr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .in_item   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (job_push),
    .job       (job_in)
  );

  // Decouple classification from serialization
  afr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_job  (job_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // Back: expand each job into its results behind an output register
  afr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job       (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A job is only produced for an accepted item, which needs a free slot
  `AFR_ASSERT_SAME(a_push_has_room, clk, rst_n, job_push, !q_full, "job pushed into full queue")
  // The back retires only jobs that are present
  `AFR_ASSERT_SAME(a_pop_has_job, clk, rst_n, q_pop, q_valid, "pop from empty queue")
  // A result without a reply byte is always a lone unpair result
  `AFR_ASSERT_SAME(a_idle_result, clk, rst_n, out_valid && !out_data.tx_valid, out_data.unpaired_event && out_data.frame_last && (out_data.tx_byte == 8'h00), "bad non-reply result")

endmodule

>>> dv/tb_api_frame_receiver_with_reply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_api_frame_receiver_with_reply
// Self-checking bench for the API frame receiver with reply. Each accepted
// input item (received byte or millisecond tick) runs through a behavioral
// copy of the frame window, the pairing, charge and drive rules and the
// unpair timer. Every reply byte and unpair notice is checked field by field
// in order. Directed frame sequences run under random idling on both
// channels, and the receiver also holds off long enough to back up the block.
// ----------------------------------------------------------------------------
module tb_api_frame_receiver_with_reply;

  // --------------------------------------------------------------------------
  // Clock, reset, DUT ports
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_valid = 1'b0;
  logic                           in_stall;
  afr_pkg::afr_in_t               in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  afr_pkg::afr_out_t              out_data;
  logic                           cfg_we = 1'b0;
  logic [afr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [afr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  always #6 clk = ~clk;

  api_frame_receiver_with_reply u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  afr_pkg::afr_in_t  rx_stream[$];     // items waiting to be offered to the block
  afr_pkg::afr_out_t reply_beats[$];   // reply bytes and unpair notices still due

  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;

  // Long receiver hold-off, requested by the stimulus, counted by the stall process
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  int unsigned n_errors     = 0;
  int unsigned n_queued     = 0;
  int unsigned n_accepted   = 0;
  int unsigned n_replies    = 0;
  int unsigned n_pairings   = 0;
  int unsigned n_charging   = 0;
  int unsigned n_drives     = 0;
  int unsigned n_unpairs    = 0;
  int unsigned n_in_blocked = 0;
  int unsigned n_settings   = 0;

  // Receiver copy: configuration
  logic [15:0] cfg_timeout = afr_pkg::RST_UNPAIR_TIMEOUT;
  logic [7:0]  cfg_refill  = afr_pkg::RST_REFILL_CHARGE;
  logic [7:0]  cfg_step    = afr_pkg::RST_CHARGE_STEP;
  logic [7:0]  cfg_neutral = afr_pkg::RST_JOY_NEUTRAL;

  // Receiver copy: state
  logic [7:0]  rx_window [afr_pkg::WIN_LEN] = '{default: 8'h00};
  logic        frame_open     = 1'b0;
  logic        paired         = 1'b0;
  logic [7:0]  peer_addr      = 8'h00;
  logic        refill_pending = 1'b0;
  logic [7:0]  charge         = afr_pkg::RST_CHARGE;
  logic        timer_running  = 1'b0;
  logic [15:0] timer_count    = 16'h0000;

  // --------------------------------------------------------------------------
  // Receiver behavior: advance the state on one accepted item and append the
  // results it causes to reply_beats.
  // --------------------------------------------------------------------------
  task automatic step_receiver(input afr_pkg::afr_in_t it);
    logic [7:0]        sum;
    logic [7:0]        chk;
    logic [7:0]        tx [afr_pkg::TX_BEATS];
    logic              ev_pair, ev_chg, ev_drive;
    logic [7:0]        thr, dir, digi;
    logic [1:0]        cannon;
    afr_pkg::afr_out_t r;
    int                i;
    ev_pair  = 1'b0;
    ev_chg   = 1'b0;
    ev_drive = 1'b0;
    thr      = 8'h00;
    dir      = 8'h00;
    cannon   = afr_pkg::CANNON_NONE;

    // Tick: run down the unpair timer; expiry drops the pairing
    if (it.mode) begin
      if (!timer_running) return;
      if (timer_count != 0) timer_count = timer_count - 1'b1;
      if (timer_count != 0) return;
      timer_running = 1'b0;
      paired = 1'b0;
      r = '0;
      r.frame_last = 1'b1;
      r.unpaired_event = 1'b1;
      r.charge_level = charge;
      reply_beats.push_back(r);
      n_unpairs++;
      return;
    end

    // Start of frame clears the window, oldest slot last until it shifts down
    if (it.rx_byte == afr_pkg::SOF) begin
      foreach (rx_window[k]) rx_window[k] = 8'h00;
      rx_window[afr_pkg::WIN_LEN-1] = afr_pkg::SOF;
      frame_open = 1'b1;
      return;
    end
    if (!frame_open) return;
    for (i = 0; i < afr_pkg::WIN_LEN - 1; i++) rx_window[i] = rx_window[i+1];
    rx_window[afr_pkg::WIN_LEN-1] = it.rx_byte;

    if (rx_window[0] != afr_pkg::SOF) return;
    sum = 8'h00;
    for (i = 3; i < 12; i++) sum = sum + rx_window[i];
    chk = afr_pkg::CKS_BASE - sum;
    if (rx_window[12] != chk || rx_window[1] != afr_pkg::LEN_HI ||
        rx_window[2] != afr_pkg::RX_LEN_LO || rx_window[3] != afr_pkg::RX_API_ID ||
        rx_window[4] != afr_pkg::FRAME_TAG) return;

    if (!paired && rx_window[8] == afr_pkg::CMD_PAIR &&
        rx_window[9] == afr_pkg::FRAME_TAG) begin
      peer_addr = rx_window[10];
      paired = 1'b1;
      refill_pending = 1'b1;
      ev_pair = 1'b1;
    end else if (paired && rx_window[4] == afr_pkg::FRAME_TAG &&
                 rx_window[5] == peer_addr) begin
      // Any frame from the peer restarts the timer; the first one refills
      timer_running = 1'b1;
      timer_count = cfg_timeout;
      if (refill_pending) begin
        charge = cfg_refill;
        refill_pending = 1'b0;
      end
      if (rx_window[8] == afr_pkg::CMD_CHARGE) begin
        charge = charge + cfg_step;
        ev_chg = 1'b1;
      end else if (rx_window[8] == afr_pkg::CMD_DRIVE) begin
        thr  = rx_window[9];
        dir  = rx_window[10];
        digi = rx_window[11];
        if (charge == 8'h00) begin
          thr = cfg_neutral;
          dir = cfg_neutral;
        end else begin
          // Moving costs one unit, firing another if anything is left
          if (thr != cfg_neutral || dir != cfg_neutral) charge = charge - 1'b1;
          if (digi == afr_pkg::DIGI_FIRE && charge != 8'h00) begin
            charge = charge - 1'b1;
            cannon = afr_pkg::CANNON_START;
          end
          if (digi == afr_pkg::DIGI_HOLD) cannon = afr_pkg::CANNON_STOP;
        end
        ev_drive = 1'b1;
      end
    end
    frame_open = 1'b0;

    tx[0] = afr_pkg::SOF;
    tx[1] = afr_pkg::LEN_HI;
    tx[2] = afr_pkg::TX_LEN_LO;
    tx[3] = afr_pkg::TX_API_ID;
    tx[4] = afr_pkg::TX_OPT;
    tx[5] = afr_pkg::FRAME_TAG;
    tx[6] = peer_addr;
    tx[7] = afr_pkg::TX_STATUS;
    tx[8] = charge;
    sum = 8'h00;
    for (i = 3; i < 9; i++) sum = sum + tx[i];
    tx[9] = afr_pkg::CKS_BASE - sum;

    for (i = 0; i < afr_pkg::TX_BEATS; i++) begin
      r = '0;
      r.tx_valid = 1'b1;
      r.tx_byte = tx[i];
      r.frame_last = (i == afr_pkg::TX_BEATS - 1);
      r.charge_level = charge;
      // Events and drive values ride on the first byte only
      if (i == 0) begin
        r.paired_event = ev_pair;
        r.charging_event = ev_chg;
        r.drive_event = ev_drive;
        r.throttle = thr;
        r.direction = dir;
        r.cannon_cmd = cannon;
      end
      reply_beats.push_back(r);
    end
    n_replies++;
    if (ev_pair) n_pairings++;
    if (ev_chg) n_charging++;
    if (ev_drive) n_drives++;
  endtask

  // --------------------------------------------------------------------------
  // Input driver: offer queued items, hold a stalled item unchanged
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        step_receiver(in_data);
        n_accepted++;
      end
      if (in_valid && in_stall) n_in_blocked++;
      if (!in_valid || !in_stall) begin
        if (rx_stream.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= rx_stream.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      n_errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    afr_pkg::afr_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (reply_beats.size() == 0) begin
        n_errors++;
        $display("%0t ns: unexpected result, expected none, actual 0x%0h", $time, out_data);
      end else begin
        want = reply_beats.pop_front();
        check_field("tx_valid",       want.tx_valid,       out_data.tx_valid);
        check_field("tx_byte",        want.tx_byte,        out_data.tx_byte);
        check_field("frame_last",     want.frame_last,     out_data.frame_last);
        check_field("paired_event",   want.paired_event,   out_data.paired_event);
        check_field("unpaired_event", want.unpaired_event, out_data.unpaired_event);
        check_field("charging_event", want.charging_event, out_data.charging_event);
        check_field("drive_event",    want.drive_event,    out_data.drive_event);
        check_field("throttle",       want.throttle,       out_data.throttle);
        check_field("direction",      want.direction,      out_data.direction);
        check_field("cannon_cmd",     want.cannon_cmd,     out_data.cannon_cmd);
        check_field("charge_level",   want.charge_level,   out_data.charge_level);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall: long hold-off first, otherwise random at the current rate
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 300;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b);
    afr_pkg::afr_in_t it;
    it.mode = 1'b0;
    it.rx_byte = b;
    rx_stream.push_back(it);
    n_queued++;
  endtask

  task automatic queue_tick();
    afr_pkg::afr_in_t it;
    it.mode = 1'b1;
    it.rx_byte = 8'($urandom_range(255));
    rx_stream.push_back(it);
    n_queued++;
  endtask

  // A start byte inside a frame restarts it; keep frame bodies free of it
  function automatic logic [7:0] clean_byte(input logic [7:0] b);
    return (b == afr_pkg::SOF) ? (b ^ 8'h01) : b;
  endfunction

  // Queue a complete 13-byte frame; corrupt flips its checksum
  task automatic queue_frame(input logic [7:0] addr, input logic [7:0] cmd,
                             input logic [7:0] b9, input logic [7:0] b10,
                             input logic [7:0] b11, input bit corrupt);
    logic [7:0] body [afr_pkg::WIN_LEN];
    logic [7:0] sum;
    int         i;
    body[0]  = afr_pkg::SOF;
    body[1]  = afr_pkg::LEN_HI;
    body[2]  = afr_pkg::RX_LEN_LO;
    body[3]  = afr_pkg::RX_API_ID;
    body[4]  = afr_pkg::FRAME_TAG;
    body[5]  = clean_byte(addr);
    body[7]  = clean_byte(8'($urandom_range(255)));
    body[8]  = clean_byte(cmd);
    body[9]  = clean_byte(b9);
    body[10] = clean_byte(b10);
    body[11] = clean_byte(b11);
    // Reroll the free byte until neither it nor the checksum is a start byte
    do begin
      body[6] = 8'($urandom_range(255));
      sum = 8'h00;
      for (i = 3; i < 12; i++) sum = sum + body[i];
      body[12] = afr_pkg::CKS_BASE - sum;
    end while (body[6] == afr_pkg::SOF || body[12] == afr_pkg::SOF);
    if (corrupt) begin
      body[12] = body[12] ^ (8'h01 << $urandom_range(7));
      if (body[12] == afr_pkg::SOF) body[12] = body[12] ^ 8'h80;
    end
    for (i = 0; i < afr_pkg::WIN_LEN; i++) queue_byte(body[i]);
  endtask

  // Registers change only while nothing is in flight
  task automatic write_reg(input logic [afr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [afr_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      afr_pkg::CFG_UNPAIR_TIMEOUT: cfg_timeout = val;
      afr_pkg::CFG_REFILL_CHARGE:  cfg_refill = val[7:0];
      afr_pkg::CFG_CHARGE_STEP:    cfg_step = val[7:0];
      afr_pkg::CFG_JOY_NEUTRAL:    cfg_neutral = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every item is taken and every result is back, then settle;
  // check between edges so the driver's updates have landed
  task automatic drain();
    do @(negedge clk);
    while (rx_stream.size() != 0 || in_valid || reply_beats.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver heavily
    in_idle_pct  = 15;
    out_idle_pct = 71;

    // Reset values except a short timeout
    write_reg(afr_pkg::CFG_UNPAIR_TIMEOUT, 16'd3);
    n_settings++;
    queue_byte(8'h00);                    // no frame open: drop
    queue_tick();                         // timer idle: no result
    // Valid drive frame before any pairing: reply with address 0, no rule
    queue_frame(8'h00, afr_pkg::CMD_DRIVE, 8'h40, 8'hC0, afr_pkg::DIGI_FIRE, 1'b0);
    // Bad checksum: no reply, frame stays open until the next start byte
    queue_frame(8'h12, afr_pkg::CMD_CHARGE, 8'h00, 8'h00, 8'h00, 1'b1);
    queue_frame(8'h00, afr_pkg::CMD_PAIR, afr_pkg::FRAME_TAG, 8'hA5, 8'h00, 1'b0);
    // Refill, then step
    queue_frame(8'hA5, afr_pkg::CMD_CHARGE, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_frame(8'hA5, afr_pkg::CMD_DRIVE, 8'hFF, 8'h00, afr_pkg::DIGI_FIRE, 1'b0);
    // Unknown fire code: move cost only, no cannon command
    queue_frame(8'hA5, afr_pkg::CMD_DRIVE, 8'h01, 8'h80, 8'h05, 1'b0);
    repeat (3) queue_tick();              // expire
    drain();

    // Idling swapped; charge runs out, zero timeout
    in_idle_pct  = 71;
    out_idle_pct = 15;
    write_reg(afr_pkg::CFG_UNPAIR_TIMEOUT, 16'd0);
    write_reg(afr_pkg::CFG_REFILL_CHARGE, 16'd1);
    write_reg(afr_pkg::CFG_CHARGE_STEP, 16'd255);
    write_reg(afr_pkg::CFG_JOY_NEUTRAL, 16'd0);
    n_settings++;
    queue_frame(8'h00, afr_pkg::CMD_PAIR, afr_pkg::FRAME_TAG, 8'hFF, 8'hFF, 1'b0);
    // Move empties the charge, so the fire request is dropped
    queue_frame(8'hFF, afr_pkg::CMD_DRIVE, 8'h10, 8'h00, afr_pkg::DIGI_FIRE, 1'b0);
    // Empty: forced neutral, no cannon command
    queue_frame(8'hFF, afr_pkg::CMD_DRIVE, 8'h33, 8'h44, afr_pkg::DIGI_HOLD, 1'b0);
    queue_tick();                         // zero timeout expires on the first tick
    drain();

    // No idling; register extremes; receiver holds off while frames pile up
    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_reg(afr_pkg::CFG_UNPAIR_TIMEOUT, 16'hFFFF);
    write_reg(afr_pkg::CFG_REFILL_CHARGE, 16'd255);
    write_reg(afr_pkg::CFG_CHARGE_STEP, 16'd2);
    write_reg(afr_pkg::CFG_JOY_NEUTRAL, 16'd255);
    n_settings++;
    hold_req = 1'b1;
    queue_frame(8'h00, afr_pkg::CMD_PAIR, afr_pkg::FRAME_TAG, 8'h3C, 8'h00, 1'b0);
    // Refill to full, then the step wraps
    queue_frame(8'h3C, afr_pkg::CMD_CHARGE, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_frame(8'h3C, afr_pkg::CMD_DRIVE, 8'h20, 8'h90, afr_pkg::DIGI_HOLD, 1'b0);
    // Foreign sender: reply only
    queue_frame(8'hC3, afr_pkg::CMD_CHARGE, 8'h00, 8'h00, 8'h00, 1'b0);
    repeat (3) queue_tick();              // offered while the queue is full
    drain();

    $display("Covered %0d of %0d items in %0d settings: %0d replies, %0d pairings,",
             n_accepted, n_queued, n_settings, n_replies, n_pairings);
    $display("  %0d charging, %0d drives, %0d unpair notices, %0d cycles input held off",
             n_charging, n_drives, n_unpairs, n_in_blocked);
    if (n_errors == 0 && reply_beats.size() == 0) begin
      $display("api_frame_receiver_with_reply test passed");
    end else begin
      $display("api_frame_receiver_with_reply test failed");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #4_000_000;
    $display("Timeout with %0d items queued and %0d results due",
             rx_stream.size(), reply_beats.size());
    $display("api_frame_receiver_with_reply test failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/afr_pkg.sv
hw/rtl/afr_front.sv
hw/rtl/afr_queue.sv
hw/rtl/afr_back.sv
hw/rtl/api_frame_receiver_with_reply.sv
dv/tb_api_frame_receiver_with_reply.sv
